[sv/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, command and status codes and control structs of the
// circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH = 16;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_POP_FRONT  = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // latch the accepted request and start its read
    logic exec;  // carry out the latched command and load the response
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd_legal;  // incoming command code is a known one
    logic more;       // a list has further entries after the current one
  } stat_t;

endpackage

[sv/cdq_if.sv]
// ----------------------------------------------------------------------------
// cdq_if
// Request and response channels of the circular deque, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdq_req_if;
  logic                                valid;
  logic                                ready;
  logic        [cdq_pkg::CMD_W-1:0]    cmd;
  logic signed [cdq_pkg::WORD_W-1:0]   push_value;

  modport source (output valid, cmd, push_value, input ready);
  modport sink   (input valid, cmd, push_value, output ready);
endinterface

interface cdq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdq_pkg::WORD_W-1:0]   out_value;
  logic        [cdq_pkg::STATUS_W-1:0] status;
  logic                                last;

  modport source (output valid, out_value, status, last, input ready);
  modport sink   (input valid, out_value, status, last, output ready);
endinterface

[sv/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Handshake controller: accepts one request at a time and sequences its
// response(s) into the output register.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  cdq_pkg::stat_t stat_i,
  output cdq_pkg::ctrl_t ctrl_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   slot_free;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;

  assign ctrl_o.load = accept;
  assign ctrl_o.exec = (state_q == S_EXEC) && slot_free;
  assign rsp_valid_o = rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      // load a new response on execute, otherwise hold until taken
      rsp_valid_q <= ctrl_o.exec || (rsp_valid_q && !rsp_ready_i);
      unique case (state_q)
        S_IDLE: begin
          // drop unknown command codes without a response
          if (accept && stat_i.cmd_legal) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free && !stat_i.more) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/cdq_dp.sv]
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: entry memory, head/tail pointers, fill count, list cursor
// and the response payload register.
// ----------------------------------------------------------------------------
module cdq_dp #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cdq_pkg::ctrl_t                      ctrl_i,
  output cdq_pkg::stat_t                      stat_o,
  input  logic        [cdq_pkg::CMD_W-1:0]    req_cmd_i,
  input  logic signed [cdq_pkg::WORD_W-1:0]   req_push_value_i,
  output logic signed [cdq_pkg::WORD_W-1:0]   rsp_out_value_o,
  output logic        [cdq_pkg::STATUS_W-1:0] rsp_status_o,
  output logic                                rsp_last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

  logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];

  logic [AW-1:0]              head_q, tail_q, cursor_q;
  logic [CW-1:0]              count_q, list_cnt_q;
  cdq_pkg::cmd_e              cmd_q;
  logic [cdq_pkg::WORD_W-1:0] word_q;
  logic [cdq_pkg::WORD_W-1:0] rd_data_q;

  logic [cdq_pkg::WORD_W-1:0]   out_value_q, out_value_d;
  logic [cdq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                         last_q, last_d;

  logic          full, empty, list_last;
  logic          cmd_legal;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  cdq_pkg::cmd_e in_cmd;

  assign in_cmd    = cdq_pkg::cmd_e'(req_cmd_i);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign list_last = (list_cnt_q + CW'(1) == count_q);

  always_comb begin
    unique case (in_cmd) inside
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_PUSH_BACK,
      cdq_pkg::CMD_POP_BACK, cdq_pkg::CMD_LIST: cmd_legal = 1'b1;
      default: cmd_legal = 1'b0;
    endcase
  end

  assign stat_o.cmd_legal = cmd_legal;
  assign stat_o.more      = (cmd_q == cdq_pkg::CMD_LIST) && !empty && !list_last;

  // read address: advance the cursor while listing, pick the end on a new request
  always_comb begin
    if (ctrl_i.exec && cmd_q == cdq_pkg::CMD_LIST) begin
      rd_addr = wrap_inc(cursor_q);
    end else if (ctrl_i.load) begin
      rd_addr = (in_cmd == cdq_pkg::CMD_POP_BACK) ? tail_q : head_q;
    end else begin
      rd_addr = cursor_q;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = head_q;
    if (ctrl_i.exec && !full) begin
      if (cmd_q == cdq_pkg::CMD_PUSH_FRONT) begin
        we = 1'b1;
        wa = wrap_dec(head_q);
      end else if (cmd_q == cdq_pkg::CMD_PUSH_BACK) begin
        we = 1'b1;
        wa = wrap_inc(tail_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= word_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    out_value_d = '0;
    status_d    = cdq_pkg::ST_OK;
    last_d      = 1'b1;
    case (cmd_q) inside
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_d = cdq_pkg::ST_FULL;
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          out_value_d = rd_data_q;
        end
      end
      cdq_pkg::CMD_LIST: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          out_value_d = rd_data_q;
          last_d      = list_last;
        end
      end
      default: status_d = cdq_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= in_cmd;
      word_q <= req_push_value_i;
    end
    if (ctrl_i.exec) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= AW'(DEPTH - 1);
      count_q    <= '0;
      cursor_q   <= '0;
      list_cnt_q <= '0;
    end else begin
      cursor_q <= rd_addr;
      if (ctrl_i.load) begin
        list_cnt_q <= '0;
      end
      if (ctrl_i.exec) begin
        case (cmd_q)
          cdq_pkg::CMD_PUSH_FRONT: begin
            if (!full) begin
              head_q  <= wrap_dec(head_q);
              count_q <= count_q + CW'(1);
            end
          end
          cdq_pkg::CMD_PUSH_BACK: begin
            if (!full) begin
              tail_q  <= wrap_inc(tail_q);
              count_q <= count_q + CW'(1);
            end
          end
          cdq_pkg::CMD_POP_FRONT: begin
            if (!empty) begin
              head_q  <= wrap_inc(head_q);
              count_q <= count_q - CW'(1);
            end
          end
          cdq_pkg::CMD_POP_BACK: begin
            if (!empty) begin
              tail_q  <= wrap_dec(tail_q);
              count_q <= count_q - CW'(1);
            end
          end
          cdq_pkg::CMD_LIST: list_cnt_q <= list_cnt_q + CW'(1);
          default: list_cnt_q <= list_cnt_q;
        endcase
      end
    end
  end

  assign rsp_out_value_o = out_value_q;
  assign rsp_status_o    = status_q;
  assign rsp_last_o      = last_q;

endmodule

[sv/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// Fixed-depth circular double-ended queue of signed 32-bit words.
// ----------------------------------------------------------------------------
//   channel   dir   modport   payload
//   req_i     in    sink      cmd, push_value
//   rsp_o     out   source    out_value, status, last
//
// Push and pop: each request is accepted, then executed into the response
// register; a list gives one response and one memory read per entry, or one
// ST_EMPTY response when empty. An unknown command code gets no response.
// Reset is asynchronous, active low; the entry memory itself is not cleared.
// A stalled response holds the execute step; a new request is taken once the
// previous one has issued its final response, even while that one waits.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_req_if.sink   req_i,
  cdq_rsp_if.source rsp_o
);

  cdq_pkg::ctrl_t ctrl;
  cdq_pkg::stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .req_cmd_i        (req_i.cmd),
    .req_push_value_i (req_i.push_value),
    .rsp_out_value_o  (rsp_o.out_value),
    .rsp_status_o     (rsp_o.status),
    .rsp_last_o       (rsp_o.last)
  );

endmodule

[sv/cdq_checker.sv]
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic        [cdq_pkg::CMD_W-1:0]    req_cmd_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic signed [cdq_pkg::WORD_W-1:0]   rsp_out_value_i,
  input logic        [cdq_pkg::STATUS_W-1:0] rsp_status_i,
  input logic                                rsp_last_i
);

  // response stays until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_out_value_i) && $stable(rsp_status_i) && $stable(rsp_last_i))
    else $error("response payload changed while stalled");

  // a known command keeps the request side busy while it executes
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i &&
    (req_cmd_i == cdq_pkg::CMD_PUSH_FRONT || req_cmd_i == cdq_pkg::CMD_POP_FRONT ||
     req_cmd_i == cdq_pkg::CMD_PUSH_BACK  || req_cmd_i == cdq_pkg::CMD_POP_BACK  ||
     req_cmd_i == cdq_pkg::CMD_LIST) |=> !req_ready_i)
    else $error("request accepted during execute");

  // only a non-empty list gives non-final responses, all with ok status
  a_nonlast_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> rsp_status_i == cdq_pkg::ST_OK)
    else $error("non-final response with error status");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_cmd_i       (req_i.cmd),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_out_value_i (rsp_o.out_value),
  .rsp_status_i    (rsp_o.status),
  .rsp_last_i      (rsp_o.last)
);
